>>> sv/traffic_rate_ema_monitor_assert.svh
// assertion macros shared by the traffic rate monitor checker
`ifndef TRAFFIC_RATE_EMA_MONITOR_ASSERT_SVH
`define TRAFFIC_RATE_EMA_MONITOR_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define TREM_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TREM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/trem_pkg.sv
// shared types, constants and helpers of the traffic rate monitor
package trem_pkg;

	// register map
	localparam int PADDR_W = 3;
	localparam logic REG_ALPHA = 1'b0;
	localparam logic REG_WMS   = 1'b1;

	// register reset values and limits
	localparam logic [16:0] ALPHA_RST = 17'd6554;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic [15:0] WMS_RST   = 16'd1000;

	// time and fixed point constants
	localparam logic [19:0] NS_PER_MS = 20'd1000000;
	localparam logic [47:0] DELAY_MIN = 48'h8000_0000_0000;
	localparam logic [63:0] EMA_HALF  = 64'd32768;

	// elapsed nanoseconds to milliseconds: drop six bits, multiply by the
	// rounded-up reciprocal of 15625 and drop 71 more bits
	localparam logic [57:0] MS_RECIP = 58'(((72'd1 << 71) + 72'd15624) / 72'd15625);
	localparam logic [2:0]  MS_LAST  = 3'd4;

	// shared divider geometry
	localparam int DIV_DW = 66;
	localparam int DIV_SW = 44;
	localparam int DIV_CW = 7;
	localparam logic [DIV_CW-1:0] DIV_STEPS = 7'd66;

	// input queue geometry
	localparam int Q_AW = 1;
	localparam logic [Q_AW:0] Q_DEPTH = 2'd2;

	// one classified input word
	typedef struct packed {
		logic [62:0] arrival;
		logic        has_sent;
		logic [47:0] delay_smp;
		logic [31:0] add_bytes;
	} trem_item_t;

	// effective configuration
	typedef struct packed {
		logic [16:0] alpha;
		logic [15:0] wms;
	} trem_cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_SW-1:0] divisor;
	} trem_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} trem_div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [16:0] alpha;
		logic [47:0] acc;
		logic [47:0] sample;
	} trem_ema_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] result;
	} trem_ema_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_CHK,
		ST_DLY_W,
		ST_WIN,
		ST_MS_W,
		ST_RATE_GO,
		ST_RATE_W,
		ST_BW_W,
		ST_BWE_W,
		ST_OUT
	} trem_state_t;

	// count * 256000 as (count * 125) << 11
	function automatic logic [65:0] scale_rate(input logic [47:0] cnt);
		logic [54:0] ext;
		logic [54:0] m125;
		ext = {7'b0, cnt};
		m125 = (ext << 7) - (ext << 1) - ext;
		return {m125, 11'b0};
	endfunction

endpackage

>>> sv/traffic_rate_ema_monitor.sv
// Traffic rate monitor: takes one message word at a time (arrival time, optional send time,
// size) and returns one result word per message with the running message count, a moving
// average of the delay, and moving averages of message and byte rate that are refreshed
// each time a measurement window of at least window_ms closes. A message that does not
// close a window passes through the sequencer, and through the shared multiply-accumulate
// unit, which forms its 24x17 partial products in turn, when it also updates a running
// delay average. A message that closes a window also has its elapsed milliseconds formed
// by a reciprocal multiply, then the shared restoring divider produces one quotient bit
// per cycle for two divisions (message rate, byte rate). A two-word input queue lets new
// messages be taken while the back end works and a result waits to be read.
module traffic_rate_ema_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [trem_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        msg_valid,
	output logic                        msg_stall,
	input  logic [62:0]                 arrival_ns,
	input  logic [62:0]                 sent_ns,
	input  logic [31:0]                 msg_bytes,
	input  logic                        has_payload,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [31:0]                 rate_avg_q8,
	output logic signed [47:0]          delay_avg_ns,
	output logic [47:0]                 bandwidth_avg_q8,
	output logic [63:0]                 total_messages,
	output logic                        window_closed
);
	import trem_pkg::*;

	logic          cfg_wr;
	logic [16:0]   alpha_q;
	logic [15:0]   wms_q;
	trem_cfg_t     cfg;
	logic          q_full;
	logic          q_empty;
	logic          q_push;
	logic          q_pop;
	trem_item_t    push_item;
	trem_item_t    pop_item;
	trem_div_req_t div_req;
	trem_div_rsp_t div_rsp;
	trem_ema_req_t ema_req;
	trem_ema_rsp_t ema_rsp;
	logic [47:0]   delay_bits;

	// register writes
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			wms_q   <= WMS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ALPHA: alpha_q <= pwdata[16:0];
				REG_WMS:   wms_q   <= pwdata[15:0];
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[2])
			REG_ALPHA: prdata = {15'b0, alpha_q};
			REG_WMS:   prdata = {16'b0, wms_q};
		endcase
	end

	// effective alpha clamps at one, zero window acts as one millisecond
	assign cfg.alpha = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign cfg.wms   = (wms_q == '0) ? 16'd1 : wms_q;

	trem_front u_front (
		.msg_valid   (msg_valid),
		.msg_stall   (msg_stall),
		.arrival_ns  (arrival_ns),
		.sent_ns     (sent_ns),
		.msg_bytes   (msg_bytes),
		.has_payload (has_payload),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	trem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	trem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	trem_ema u_ema (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ema_req),
		.rsp    (ema_rsp)
	);

	trem_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.q_empty          (q_empty),
		.q_item           (pop_item),
		.q_pop            (q_pop),
		.div_req          (div_req),
		.div_rsp          (div_rsp),
		.ema_req          (ema_req),
		.ema_rsp          (ema_rsp),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.rate_avg_q8      (rate_avg_q8),
		.delay_avg_bits   (delay_bits),
		.bandwidth_avg_q8 (bandwidth_avg_q8),
		.total_messages   (total_messages),
		.window_closed    (window_closed)
	);

	assign delay_avg_ns = $signed(delay_bits);

endmodule

>>> sv/trem_front.sv
// front end: accepts message words and classifies them for the queue
module trem_front (
	input  logic                 msg_valid,
	output logic                 msg_stall,
	input  logic [62:0]          arrival_ns,
	input  logic [62:0]          sent_ns,
	input  logic [31:0]          msg_bytes,
	input  logic                 has_payload,
	input  logic                 q_full,
	output logic                 q_push,
	output trem_pkg::trem_item_t q_item
);
	import trem_pkg::*;

	logic [63:0] diff;
	logic [47:0] diff_sat;

	// arrival minus send, two's complement
	assign diff = {1'b0, arrival_ns} - {1'b0, sent_ns};

	// clamp delay to the 48-bit signed range
	always_comb begin
		if (diff[63:47] == '0 || diff[63:47] == '1) begin
			diff_sat = diff[47:0];
		end else if (diff[63]) begin
			diff_sat = DELAY_MIN;
		end else begin
			diff_sat = ~DELAY_MIN;
		end
	end

	// classified word, delay biased to unsigned
	always_comb begin
		q_item.arrival   = arrival_ns;
		q_item.has_sent  = (sent_ns != '0);
		q_item.delay_smp = diff_sat ^ DELAY_MIN;
		q_item.add_bytes = has_payload ? msg_bytes : '0;
	end

	// handshake
	assign msg_stall = q_full;
	assign q_push    = msg_valid & ~q_full;

endmodule

>>> sv/trem_queue.sv
// two-word queue between front end and back end
module trem_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trem_pkg::trem_item_t push_item,
	input  logic                 pop,
	output trem_pkg::trem_item_t pop_item,
	output logic                 full,
	output logic                 empty
);
	import trem_pkg::*;

	trem_item_t      mem_q [2**Q_AW];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign full     = (cnt_q == Q_DEPTH);
	assign empty    = (cnt_q == '0);

endmodule

>>> sv/trem_div.sv
// shared restoring divider, one quotient bit per cycle
module trem_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  trem_pkg::trem_div_req_t req,
	output trem_pkg::trem_div_rsp_t rsp
);
	import trem_pkg::*;

	logic [DIV_SW-1:0] rem_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_SW-1:0] dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_SW:0]   shifted;
	logic [DIV_SW:0]   rem_next;
	logic              ge;

	// one restoring step
	assign shifted  = {rem_q, quo_q[DIV_DW-1]};
	assign ge       = (shifted >= {1'b0, dvs_q});
	assign rem_next = ge ? (shifted - {1'b0, dvs_q}) : shifted;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next[DIV_SW-1:0];
			quo_q <= {quo_q[DIV_DW-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> sv/trem_ema.sv
// moving average unit: four 24x17 partial products accumulated in turn; a zero average takes the sample
module trem_ema (
	input  logic                    clk,
	input  logic                    arst_n,
	input  trem_pkg::trem_ema_req_t req,
	output trem_pkg::trem_ema_rsp_t rsp
);
	import trem_pkg::*;

	localparam logic [2:0] LAST_STEP = 3'd7;

	logic [16:0] alpha_q;
	logic [16:0] wc_q;
	logic [47:0] acc_q;
	logic [47:0] smp_q;
	logic [63:0] sum_q;
	logic [40:0] prod_q;
	logic [2:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [1:0]  sel;
	logic [23:0] opa;
	logic [16:0] opb;
	logic [63:0] addend;

	assign sel = cnt_q[2:1];

	// partial product operand select
	always_comb begin
		unique case (sel)
			2'd0: begin
				opa = smp_q[23:0];
				opb = alpha_q;
			end
			2'd1: begin
				opa = smp_q[47:24];
				opb = alpha_q;
			end
			2'd2: begin
				opa = acc_q[23:0];
				opb = wc_q;
			end
			2'd3: begin
				opa = acc_q[47:24];
				opb = wc_q;
			end
		endcase
	end

	assign addend = sel[0] ? (64'(prod_q) << 24) : 64'(prod_q);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.acc == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// multiply on even steps, accumulate on odd steps
	always_ff @(posedge clk) begin
		if (req.start) begin
			alpha_q <= req.alpha;
			wc_q    <= ALPHA_ONE - req.alpha;
			acc_q   <= req.acc;
			smp_q   <= req.sample;
			sum_q   <= (req.acc == '0) ? {req.sample, 16'b0} : EMA_HALF;
		end else if (busy_q) begin
			if (!cnt_q[0]) begin
				prod_q <= opa * opb;
			end else begin
				sum_q <= sum_q + addend;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = sum_q[63:16];

endmodule

>>> sv/trem_back.sv
// back end: window counters, averages and the result register
module trem_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  trem_pkg::trem_cfg_t     cfg,
	input  logic                    q_empty,
	input  trem_pkg::trem_item_t    q_item,
	output logic                    q_pop,
	output trem_pkg::trem_div_req_t div_req,
	input  trem_pkg::trem_div_rsp_t div_rsp,
	output trem_pkg::trem_ema_req_t ema_req,
	input  trem_pkg::trem_ema_rsp_t ema_rsp,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [31:0]             rate_avg_q8,
	output logic [47:0]             delay_avg_bits,
	output logic [47:0]             bandwidth_avg_q8,
	output logic [63:0]             total_messages,
	output logic                    window_closed
);
	import trem_pkg::*;

	trem_state_t state_q;
	trem_state_t state_d;
	trem_item_t  cur_q;
	logic        open_q;
	logic [62:0] start_q;
	logic [31:0] msgs_q;
	logic [47:0] bytes_q;
	logic [63:0] total_q;
	logic [47:0] delay_q;
	logic [31:0] rate_q;
	logic [47:0] bw_q;
	logic        close_q;
	logic [63:0] elapsed_q;
	logic [35:0] thr_q;
	logic [43:0] ms_q;
	logic [56:0] ms_x_q;
	logic [2:0]  ms_cnt_q;
	logic [57:0] ms_prod_q;
	logic [59:0] ms_acc_q;
	logic        res_valid_q;
	logic [31:0] res_rate_q;
	logic [47:0] res_delay_q;
	logic [47:0] res_bw_q;
	logic [63:0] res_total_q;
	logic        res_closed_q;
	logic        out_load;
	logic [62:0] start_eff;
	logic [48:0] bytes_sum;
	logic [47:0] rate_sat;
	logic [47:0] bw_sat;
	logic [28:0] ms_opa;
	logic [28:0] ms_opb;
	logic [59:0] ms_sum;

	// window start for this word, counter sums and rate clamps
	assign start_eff = open_q ? start_q : cur_q.arrival;
	assign bytes_sum = {1'b0, bytes_q} + 49'(cur_q.add_bytes);
	assign rate_sat  = (div_rsp.quotient[65:32] != '0) ? 48'(32'hFFFF_FFFF)
		: {16'b0, div_rsp.quotient[31:0]};
	assign bw_sat    = (div_rsp.quotient[65:48] != '0) ? '1 : div_rsp.quotient[47:0];

	// reciprocal multiply operands, one 29x29 partial product per step
	always_comb begin
		unique case (ms_cnt_q[1:0])
			2'd0: begin
				ms_opa = ms_x_q[28:0];
				ms_opb = MS_RECIP[28:0];
			end
			2'd1: begin
				ms_opa = ms_x_q[28:0];
				ms_opb = MS_RECIP[57:29];
			end
			2'd2: begin
				ms_opa = {1'b0, ms_x_q[56:29]};
				ms_opb = MS_RECIP[28:0];
			end
			2'd3: begin
				ms_opa = {1'b0, ms_x_q[56:29]};
				ms_opb = MS_RECIP[57:29];
			end
		endcase
	end

	// partial product sum, low 29 bits dropped once they can no longer carry
	always_comb begin
		unique case (ms_cnt_q)
			3'd1:       ms_sum = {31'b0, ms_prod_q[57:29]};
			3'd2, 3'd3: ms_sum = ms_acc_q + {2'b0, ms_prod_q};
			3'd4:       ms_sum = {29'b0, ms_acc_q[59:29]} + {2'b0, ms_prod_q};
			default:    ms_sum = ms_acc_q;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit requests
	always_comb begin
		state_d          = state_q;
		q_pop            = 1'b0;
		out_load         = 1'b0;
		div_req          = '0;
		ema_req          = '0;
		ema_req.alpha    = cfg.alpha;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (cur_q.has_sent && delay_q != '0) begin
					ema_req.start  = 1'b1;
					ema_req.acc    = delay_q ^ DELAY_MIN;
					ema_req.sample = cur_q.delay_smp;
					state_d        = ST_DLY_W;
				end else begin
					state_d = ST_WIN;
				end
			end
			ST_DLY_W: begin
				if (ema_rsp.done) begin
					state_d = ST_WIN;
				end
			end
			ST_WIN: begin
				if (close_q) begin
					state_d = ST_MS_W;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MS_W: begin
				if (ms_cnt_q == MS_LAST) begin
					state_d = ST_RATE_GO;
				end
			end
			ST_RATE_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = scale_rate({16'b0, msgs_q});
				div_req.divisor  = ms_q;
				state_d          = ST_RATE_W;
			end
			ST_RATE_W: begin
				// rate average runs while the divider does the byte rate
				if (div_rsp.done) begin
					ema_req.start    = 1'b1;
					ema_req.acc      = {16'b0, rate_q};
					ema_req.sample   = rate_sat;
					div_req.start    = 1'b1;
					div_req.dividend = scale_rate(bytes_q);
					div_req.divisor  = ms_q;
					state_d          = ST_BW_W;
				end
			end
			ST_BW_W: begin
				if (div_rsp.done) begin
					ema_req.start  = 1'b1;
					ema_req.acc    = bw_q;
					ema_req.sample = bw_sat;
					state_d        = ST_BWE_W;
				end
			end
			ST_BWE_W: begin
				if (ema_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// monitor state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			start_q     <= '0;
			msgs_q      <= '0;
			bytes_q     <= '0;
			total_q     <= '0;
			delay_q     <= '0;
			rate_q      <= '0;
			bw_q        <= '0;
			close_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_UPD: begin
					open_q  <= 1'b1;
					start_q <= start_eff;
					total_q <= total_q + 64'd1;
					if (msgs_q != '1) begin
						msgs_q <= msgs_q + 32'd1;
					end
					bytes_q <= bytes_sum[48] ? '1 : bytes_sum[47:0];
				end
				ST_CHK: begin
					close_q <= !elapsed_q[63] && (elapsed_q[62:0] >= {27'b0, thr_q});
					if (cur_q.has_sent && delay_q == '0) begin
						delay_q <= cur_q.delay_smp ^ DELAY_MIN;
					end
				end
				ST_DLY_W: begin
					if (ema_rsp.done) begin
						delay_q <= ema_rsp.result ^ DELAY_MIN;
					end
				end
				ST_BW_W: begin
					if (ema_rsp.done) begin
						rate_q <= ema_rsp.result[31:0];
					end
				end
				ST_BWE_W: begin
					// fold byte rate and open a new window at this arrival
					if (ema_rsp.done) begin
						bw_q    <= ema_rsp.result;
						msgs_q  <= '0;
						bytes_q <= '0;
						start_q <= cur_q.arrival;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// word under work, window timing and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (state_q == ST_UPD) begin
			elapsed_q <= {1'b0, cur_q.arrival} - {1'b0, start_eff};
			thr_q     <= 36'(cfg.wms) * 36'(NS_PER_MS);
		end
		// elapsed milliseconds by reciprocal multiply
		if (state_q == ST_WIN) begin
			ms_x_q   <= elapsed_q[62:6];
			ms_cnt_q <= '0;
		end
		if (state_q == ST_MS_W) begin
			ms_cnt_q  <= ms_cnt_q + 3'd1;
			ms_prod_q <= ms_opa * ms_opb;
			ms_acc_q  <= ms_sum;
			if (ms_cnt_q == MS_LAST) begin
				ms_q <= ms_sum[56:13];
			end
		end
		if (out_load) begin
			res_rate_q   <= rate_q;
			res_delay_q  <= delay_q;
			res_bw_q     <= bw_q;
			res_total_q  <= total_q;
			res_closed_q <= close_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign rate_avg_q8      = res_rate_q;
	assign delay_avg_bits   = res_delay_q;
	assign bandwidth_avg_q8 = res_bw_q;
	assign total_messages   = res_total_q;
	assign window_closed    = res_closed_q;

endmodule

>>> sv/trem_checker.sv
// port-level checker for the traffic rate monitor, bound to the top level
`include "traffic_rate_ema_monitor_assert.svh"

module trem_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] rate_avg_q8,
	input logic [47:0] delay_avg_ns,
	input logic [47:0] bandwidth_avg_q8,
	input logic [63:0] total_messages,
	input logic        window_closed
);

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  pend_q;
	logic [63:0] last_total_q;
	logic        seen_q;

	assign in_acc  = msg_valid & ~msg_stall;
	assign out_acc = res_valid & ~res_stall;

	// words taken in but not yet delivered, and last delivered count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			last_total_q <= '0;
			seen_q       <= 1'b0;
		end else begin
			if (in_acc && !out_acc) begin
				pend_q <= pend_q + 3'd1;
			end else if (out_acc && !in_acc) begin
				pend_q <= pend_q - 3'd1;
			end
			if (out_acc) begin
				last_total_q <= total_messages;
				seen_q       <= 1'b1;
			end
		end
	end

	// a stalled result word holds
	`TREM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(rate_avg_q8) && $stable(delay_avg_ns) && $stable(bandwidth_avg_q8) && $stable(total_messages) && $stable(window_closed), "result word changed while stalled")

	// no result without a message behind it
	`TREM_ASSERT_SAME(a_no_orphan, clk, arst_n, res_valid, pend_q != 3'd0, "result word with no pending message")

	// queue, work slot and result register full means input stalls
	`TREM_ASSERT_SAME(a_full_stall, clk, arst_n, pend_q >= 3'd4, msg_stall, "message taken beyond block capacity")

	// message count advances by one per result word
	`TREM_ASSERT_SAME(a_total_step, clk, arst_n, out_acc && seen_q, total_messages == last_total_q + 64'd1, "message count did not advance by one")

endmodule

bind traffic_rate_ema_monitor trem_checker u_trem_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.msg_valid        (msg_valid),
	.msg_stall        (msg_stall),
	.res_valid        (res_valid),
	.res_stall        (res_stall),
	.rate_avg_q8      (rate_avg_q8),
	.delay_avg_ns     (delay_avg_ns),
	.bandwidth_avg_q8 (bandwidth_avg_q8),
	.total_messages   (total_messages),
	.window_closed    (window_closed)
);
